### src/swm_pkg.sv
// Shared constants and types for the sliding window maximum filter.
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_W      = 7;
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W      = $clog2(WINDOW_MAX);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Per-cycle command to every cell of the history chain.
  typedef struct packed {
    logic shift;   // take the newer neighbor's sample
    logic rotate;  // take the older neighbor's sample, first cell's sample wraps to the last
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT
  } ctrl_state_t;

endpackage

### src/swm_if.sv
// Request and result channel interfaces of the sliding window maximum filter.
interface swm_in_if;
  logic              valid;
  logic              ready;
  swm_pkg::sample_t  sample;
  logic              start_sequence;

  modport source (output valid, output sample, output start_sequence, input ready);
  modport sink   (input valid, input sample, input start_sequence, output ready);
endinterface

interface swm_out_if;
  logic              valid;
  logic              ready;
  swm_pkg::sample_t  window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

### src/swm_cell.sv
// One history cell: holds a sample, shifts toward older cells or rotates back.
module swm_cell (
  input  logic                clk,
  input  swm_pkg::cell_ctrl_t ctrl,
  input  swm_pkg::sample_t    shift_in,
  input  swm_pkg::sample_t    rot_in,
  output swm_pkg::sample_t    data_out
);

  swm_pkg::sample_t data_r;
  swm_pkg::sample_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift) begin
      data_nxt = shift_in;
    end else if (ctrl.rotate) begin
      data_nxt = rot_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

### src/swm_ctrl.sv
// Sequencer: accepts requests, drives the cell chain, tracks the maximum, emits.
module swm_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [swm_pkg::CFG_W-1:0]      cfg_len,
  input  swm_pkg::sample_t               head_data,
  swm_in_if.sink                         in_req,
  swm_out_if.source                      out_res,
  output swm_pkg::cell_ctrl_t            cell_ctrl
);

  swm_pkg::ctrl_state_t             state_r, state_nxt;
  logic [swm_pkg::IDX_W-1:0]        step_r, step_nxt;
  logic [swm_pkg::LEN_W-1:0]        fill_r, fill_nxt;
  swm_pkg::sample_t                 best_r, best_nxt;
  logic                             out_valid_r, out_valid_nxt;
  swm_pkg::sample_t                 out_data_r, out_data_nxt;
  logic [swm_pkg::LEN_W-1:0]        eff_len;
  logic                             accept;
  logic                             load;

  // Zero acts as one, values past the history depth saturate.
  always_comb begin
    if (cfg_len == '0) begin
      eff_len = swm_pkg::LEN_W'(1);
    end else if (32'(cfg_len) > 32'(swm_pkg::WINDOW_MAX)) begin
      eff_len = swm_pkg::LEN_W'(swm_pkg::WINDOW_MAX);
    end else begin
      eff_len = swm_pkg::LEN_W'(cfg_len);
    end
  end

  assign accept = in_req.valid && in_req.ready;

  always_comb begin
    state_nxt        = state_r;
    step_nxt         = step_r;
    fill_nxt         = fill_r;
    best_nxt         = best_r;
    load             = 1'b0;
    in_req.ready     = 1'b0;
    cell_ctrl.shift  = 1'b0;
    cell_ctrl.rotate = 1'b0;
    case (state_r)
      swm_pkg::ST_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          cell_ctrl.shift = 1'b1;
          step_nxt        = '0;
          state_nxt       = swm_pkg::ST_SWEEP;
          if (in_req.start_sequence) begin
            fill_nxt = swm_pkg::LEN_W'(1);
          end else if (fill_r < swm_pkg::LEN_W'(swm_pkg::WINDOW_MAX)) begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      swm_pkg::ST_SWEEP: begin
        cell_ctrl.rotate = 1'b1;
        if (step_r == '0) begin
          best_nxt = head_data;
        end else if (swm_pkg::LEN_W'(step_r) < eff_len && head_data > best_r) begin
          best_nxt = head_data;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == swm_pkg::IDX_W'(swm_pkg::WINDOW_MAX - 1)) begin
          state_nxt = swm_pkg::ST_EMIT;
        end
      end
      swm_pkg::ST_EMIT: begin
        if (fill_r < eff_len) begin
          state_nxt = swm_pkg::ST_IDLE;
        end else if (!out_valid_r || out_res.ready) begin
          load      = 1'b1;
          state_nxt = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = load || (out_valid_r && !out_res.ready);
    out_data_nxt  = load ? best_r : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swm_pkg::ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.window_max = out_data_r;

  a_accept_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == swm_pkg::ST_SWEEP && step_r == '0))
    else $error("request did not start a sweep");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swm_pkg::ST_SWEEP && step_r == swm_pkg::IDX_W'(swm_pkg::WINDOW_MAX - 1))
      |=> state_r == swm_pkg::ST_EMIT)
    else $error("sweep did not end after a full rotation");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= swm_pkg::LEN_W'(swm_pkg::WINDOW_MAX))
    else $error("fill count past history depth");

  a_short_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swm_pkg::ST_EMIT && fill_r < eff_len)
      |=> (state_r == swm_pkg::ST_IDLE && (!out_valid_r || $stable(out_data_r))))
    else $error("result emitted before window was full");

endmodule

### src/sliding_window_maximum_top.sv
// Top level of the sliding window maximum filter: config register and cell chain.
//
// Running maximum over the last window_length signed samples. Each request
// carries a sample and a start_sequence flag that discards earlier history.
// The first window_length-1 samples of a sequence produce no result; every
// later sample produces the maximum of the last window_length samples, itself
// included. The history is a chain of WINDOW_MAX cells: an accepted sample
// shifts in at the head, then the chain rotates a full turn, one cell per
// cycle, past a single comparator at the head, which returns every sample to
// its place. One request therefore occupies the block for the shift, the full
// rotation and the hand-off of the result to the output register. The output
// register lets the next request in while a result still waits; the block
// holds in its last step only if that register is still full. The user must
// write window_length through cfg_we/cfg_wdata only while no request is in
// flight; the block itself does not enforce it. Zero acts as one and values
// above WINDOW_MAX act as WINDOW_MAX. No clearing pass follows reset.
module sliding_window_maximum_top (
  input  logic                      clk,
  input  logic                      rst_n,
  swm_in_if.sink                    in_req,
  swm_out_if.source                 out_res,
  input  logic                      cfg_we,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wdata
);

  logic [swm_pkg::CFG_W-1:0] cfg_len_r;
  swm_pkg::cell_ctrl_t       cell_ctrl;
  swm_pkg::sample_t          cell_data [swm_pkg::WINDOW_MAX];

  // Window length register, resets to a window of one sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= swm_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      cfg_len_r <= cfg_wdata;
    end
  end

  // Sequencer: owns both channels, the fill count and the running maximum.
  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_len   (cfg_len_r),
    .head_data (cell_data[0]),
    .in_req    (in_req),
    .out_res   (out_res),
    .cell_ctrl (cell_ctrl)
  );

  // History chain. Cell 0 holds the newest sample; shift moves samples toward
  // the tail, rotate moves them back toward the head with the head wrapping
  // to the tail, so after WINDOW_MAX rotations every cell is back in place.
  for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++) begin : g_cell
    swm_pkg::sample_t shift_src;

    if (i == 0) begin : g_head
      assign shift_src = in_req.sample;
    end else begin : g_body
      assign shift_src = cell_data[i-1];
    end

    swm_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .shift_in (shift_src),
      .rot_in   (cell_data[(i + 1) % swm_pkg::WINDOW_MAX]),
      .data_out (cell_data[i])
    );
  end

endmodule

### bench/sliding_window_maximum_checker.sv
// Checker for the sliding window maximum filter: tracks history, predicts and compares results.
module sliding_window_maximum_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  swm_in_if                         in_req,
  swm_out_if                        out_res,
  input  logic                      cfg_we,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wdata,
  output int                        pending,
  output int                        fail_count
);

  swm_pkg::sample_t          history [swm_pkg::WINDOW_MAX];
  int unsigned               held;
  int unsigned               head;
  logic [swm_pkg::CFG_W-1:0] span_reg;
  swm_pkg::sample_t          max_q [$];
  swm_pkg::sample_t          want;
  int                        errs;

  // Store one sample and queue the window maximum it yields, if any.
  function automatic void push_sample(swm_pkg::sample_t s, logic first);
    int unsigned      span;
    int unsigned      k;
    swm_pkg::sample_t peak;
    if (first) held = 0;
    history[head] = s;
    head = (head + 1) % swm_pkg::WINDOW_MAX;
    if (held < swm_pkg::WINDOW_MAX) held++;
    span = (span_reg == 0) ? 1 :
           ((span_reg > swm_pkg::WINDOW_MAX) ? swm_pkg::WINDOW_MAX : span_reg);
    if (held >= span) begin
      peak = s;
      for (k = 1; k < span; k++) begin
        if (history[(head + swm_pkg::WINDOW_MAX - 1 - k) % swm_pkg::WINDOW_MAX] > peak)
          peak = history[(head + swm_pkg::WINDOW_MAX - 1 - k) % swm_pkg::WINDOW_MAX];
      end
      max_q = {max_q, peak};
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held     = 0;
      head     = 0;
      span_reg = 1;
      max_q.delete();
    end else begin
      if (cfg_we) span_reg = cfg_wdata;
      if (in_req.valid && in_req.ready)
        push_sample(in_req.sample, in_req.start_sequence);
      if (out_res.valid && out_res.ready) begin
        if (max_q.size() == 0) begin
          $error("unexpected result: window_max actual %0d", out_res.window_max);
          errs++;
        end else begin
          want = max_q.pop_front();
          if (out_res.window_max !== want) begin
            $error("window_max mismatch: expected %0d actual %0d", want, out_res.window_max);
            errs++;
          end
        end
      end
    end
    pending    <= max_q.size();
    fail_count <= errs;
  end

endmodule

### bench/sliding_window_maximum_top_tb.sv
// Testbench top for the sliding window maximum filter: stimulus, config phases and verdict.
module sliding_window_maximum_top_tb;

  // Quiet time after the last result: one full rotation plus margin, so a
  // request that yields no result has surely left the block.
  localparam int SETTLE_CYCLES = swm_pkg::WINDOW_MAX + 8;
  // Cycles without any accepted request or result before the run is abandoned.
  localparam int STALL_LIMIT   = 5000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [swm_pkg::CFG_W-1:0] cfg_wdata;
  int                        pending;
  int                        fail_count;
  int                        quiet_cycles;
  bit                        pace_on;

  swm_in_if  in_req ();
  swm_out_if out_res ();

  sliding_window_maximum_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sliding_window_maximum_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .out_res    (out_res),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always #10 clk = ~clk;

  // Stall the result channel at random while pacing is on; otherwise always accept.
  always @(posedge clk) begin
    out_res.ready <= !pace_on || ($urandom_range(99) >= 18);
  end

  // Abort when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mix extremes, near-zero values that tie often, and full-range noise.
  function automatic swm_pkg::sample_t pick_sample();
    case ($urandom_range(9))
      0:       return 32'sh7fffffff;
      1:       return swm_pkg::sample_t'(32'h80000000);
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return swm_pkg::sample_t'($urandom_range(20)) - 32'sd10;
      default: return swm_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Present one request, idling first at random, and hold it until taken.
  task automatic send_item(input swm_pkg::sample_t s, input logic first);
    while (pace_on && $urandom_range(99) < 18) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid          <= 1'b1;
    in_req.sample         <= s;
    in_req.start_sequence <= first;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the block go quiet.
  task automatic drain();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the window length only once the block is idle.
  task automatic write_window(input logic [swm_pkg::CFG_W-1:0] len);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One configuration phase: mostly sequences long enough to produce results,
  // some cut short at no more than the window length. The first sequence sometimes
  // carries on from the previous phase, so the new length hits mid-sequence.
  task automatic run_phase(input logic [swm_pkg::CFG_W-1:0] len, input int budget,
                           input bit calm);
    int  span;
    int  seq_len;
    int  sent;
    int  k;
    bit  carry;
    write_window(len);
    pace_on = !calm;
    span    = (len == 0) ? 1 : ((len > swm_pkg::WINDOW_MAX) ? swm_pkg::WINDOW_MAX : len);
    sent    = 0;
    carry   = $urandom_range(1);
    while (sent < budget) begin
      if ($urandom_range(99) < 15)
        seq_len = $urandom_range(span, 1);
      else
        seq_len = span + $urandom_range(2 * span + 8);
      // Keep the phase within its budget; the last sequence may end early.
      if (seq_len > budget - sent)
        seq_len = budget - sent;
      for (k = 0; k < seq_len; k++) begin
        send_item(pick_sample(), (k == 0) && !(sent == 0 && carry));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    in_req.valid          = 1'b0;
    in_req.sample         = '0;
    in_req.start_sequence = 1'b0;
    pace_on               = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window of one: samples before any start flag still count.
    send_item(32'sh7fffffff, 1'b0);
    send_item(swm_pkg::sample_t'(32'h80000000), 1'b0);
    send_item('0, 1'b0);
    send_item(-32'sd1, 1'b1);
    send_item(32'sd1, 1'b0);

    // Widen the window mid-sequence: results hold off until four samples are in.
    write_window(4);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(swm_pkg::sample_t'(32'h80000000), 1'b0);
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sd7, 1'b0);
    send_item(32'sd7, 1'b0);

    // Restart twice: the short sequence yields nothing, the next fills the window.
    send_item(swm_pkg::sample_t'(32'h80000000), 1'b1);
    send_item(-32'sd1, 1'b0);
    send_item(-32'sd2, 1'b0);
    send_item(32'sd9, 1'b1);
    send_item(swm_pkg::sample_t'(32'h80000000), 1'b0);
    send_item(swm_pkg::sample_t'(32'h80000000), 1'b0);
    send_item(swm_pkg::sample_t'(32'h80000000), 1'b0);
    send_item(32'sh7fffffff, 1'b0);

    // Random phases: full depth, zero, above depth, small and mid lengths.
    run_phase(64, 170, 1'b0);
    run_phase(0, 170, 1'b0);
    run_phase(127, 170, 1'b0);
    run_phase(2, 170, 1'b1);
    run_phase(65, 170, 1'b0);
    run_phase(9, 170, 1'b1);
    run_phase(1, 160, 1'b0);
    run_phase(33, 170, 1'b0);
    run_phase(100, 170, 1'b0);
    run_phase(5, 170, 1'b0);

    drain();
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sliding_window_maximum_top.f
src/swm_pkg.sv
src/swm_if.sv
src/swm_cell.sv
src/swm_ctrl.sv
src/sliding_window_maximum_top.sv
bench/sliding_window_maximum_checker.sv
bench/sliding_window_maximum_top_tb.sv
